[hdl/cftr_pkg.sv]
// package for camera frame timestamp recovery
// widths and register indexes; no dependencies
package cftr_pkg;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegShutterStep = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWrapPeriod = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSyncPeriod = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFramePeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFirstShift = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMatchMax = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMatchMin = 3'd6;
  localparam int DivW = 64;
endpackage

[hdl/cftr_if.sv]
// valid/ready channel interfaces for the input and result transactions
// uses no package
interface cftr_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] timestamp_word;
  logic [31:0] shutter_word;
  logic [62:0] received_ns;
  modport source (output valid, timestamp_word, shutter_word, received_ns, input ready);
  modport sink (input valid, timestamp_word, shutter_word, received_ns, output ready);
endinterface

interface cftr_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [63:0] frame_time_ns;
  logic        time_valid;
  modport source (output valid, frame_time_ns, time_valid, input ready);
  modport sink (input valid, frame_time_ns, time_valid, output ready);
endinterface

[hdl/cftr_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on cftr_pkg
module cftr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cftr_pkg::DivW-1:0]  num,
  input  logic [cftr_pkg::DivW-1:0]  den,
  output logic                       done,
  output logic [cftr_pkg::DivW-1:0]  quo,
  output logic [cftr_pkg::DivW-1:0]  rem
);
  localparam int W = cftr_pkg::DivW;
  logic [$clog2(W+1)-1:0] cnt;
  logic busy;
  logic [W-1:0] d;
  logic [W:0] trial;

  assign trial = {rem, quo[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= ($clog2(W+1))'(W);
      quo <= num;
      rem <= '0;
      d <= den;
      done <= 1'b0;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) begin
        busy <= 1'b0;
      end
      done <= (cnt == 1);
    end else begin
      done <= 1'b0;
    end
  end
endmodule

[hdl/camera_frame_timestamp_recovery_core.sv]
// camera frame timestamp recovery, top level
// depends on cftr_pkg, cftr_if, cftr_div
//
// usage: one result transaction for each input transaction. an input item
// is decoded, then the shared 64-bit divider runs twice (sync multiple or
// frame step rounding, then frame limit), with the products formed in turn
// by one 32x32 multiplier. a resync frame skips the rounding step. ready is
// low while an item is in work and while its result waits. the result holds
// on the output until taken; a stalled receiver stalls the block. reset
// restores all registers to their defaults and clears the tracking state.
// configuration writes go through cfg_we/cfg_index/cfg_data and take
// effect at once; the user must make them only while the block is idle,
// which the block itself does not enforce.
module camera_frame_timestamp_recovery_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cftr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cftr_pkg::CfgDataW-1:0]   cfg_data,
  cftr_in_if.sink                         in_ch,
  cftr_out_if.source                      out_ch
);
  localparam logic [4:0] S_IDLE = 5'd0, S_DEC = 5'd1, S_EXP = 5'd2, S_INT = 5'd3,
    S_DSYNC = 5'd4, S_DSTEP = 5'd5, S_ROUND = 5'd6, S_DLIM = 5'd7, S_M0 = 5'd8,
    S_M1 = 5'd9, S_M2 = 5'd10, S_M3 = 5'd11, S_FIN = 5'd12, S_OUT = 5'd13,
    S_LIM = 5'd14, S_WSYNC = 5'd15, S_M4 = 5'd16;

  logic [9:0]  shutter_step_us;
  logic [31:0] wrap_period_us, sync_period_ns, match_max_us, match_min_us;
  logic [23:0] frame_period_us;
  logic signed [20:0] first_frame_shift_us;

  logic [26:0] last_embedded_us;
  logic [63:0] wrap_accum_us, last_intrinsic_us, sync_multiple;
  logic [31:0] frames_since_sync;
  logic synced;

  logic [4:0] state;
  logic [31:0] ts, sh;
  logic [62:0] rx;
  logic [26:0] emb;
  logic [63:0] exp_us, step, acc, limit;
  logic neg;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] mreg;
  assign mp = ma * mb;

  // offset / 25 by reciprocal multiply, exact for 12-bit offsets
  logic [25:0] offs_prod;
  assign offs_prod = 26'(ts[11:0]) * 26'd10486;

  logic div_start, div_done;
  logic [63:0] div_num, div_den, div_q, div_r;
  cftr_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .rem(div_r));

  logic [31:0] sync_p;
  logic [23:0] frame_p;
  assign sync_p = (sync_period_ns == 0) ? 32'd1 : sync_period_ns;
  assign frame_p = (frame_period_us == 0) ? 24'd1 : frame_period_us;

  logic [63:0] intrinsic, wacc_n;
  logic signed [63:0] s_step;
  logic in_win;
  assign wacc_n = (last_embedded_us > emb) ? wrap_accum_us + 64'(wrap_period_us)
                                           : wrap_accum_us;
  assign intrinsic = wacc_n + 64'(emb) - exp_us;
  assign s_step = step;
  assign in_win = (s_step < $signed({32'd0, match_max_us}))
               && (s_step > $signed({32'd0, match_min_us}));

  logic signed [31:0] count;
  assign count = frames_since_sync;

  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_EXP: begin ma = {12'd0, sh[19:0]}; mb = {22'd0, shutter_step_us}; end
      S_DLIM: begin ma = {8'd0, frame_p}; mb = 32'd1000; end
      S_M0: begin ma = sync_multiple[31:0]; mb = sync_p; end
      S_M1: begin ma = sync_multiple[63:32]; mb = sync_p; end
      S_M2: begin ma = {8'd0, frame_p}; mb = 32'd1000; end
      S_M3: begin ma = count; mb = mreg[31:0]; end
      S_M4: begin ma = count; mb = {29'd0, mreg[34:32]}; end
      default: ;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
      shutter_step_us <= 10'd1;
      wrap_period_us <= 32'd128000000;
      sync_period_ns <= 32'd1000000000;
      frame_period_us <= 24'd100000;
      first_frame_shift_us <= '0;
      match_max_us <= 32'd150000;
      match_min_us <= 32'd50000;
      last_embedded_us <= '0;
      wrap_accum_us <= '0;
      last_intrinsic_us <= '0;
      sync_multiple <= '0;
      frames_since_sync <= '0;
      synced <= 1'b0;
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      div_start <= (state == S_DSYNC) || (state == S_DLIM);
      if (cfg_we) begin
        case (cfg_index)
          cftr_pkg::RegShutterStep: shutter_step_us <= cfg_data[9:0];
          cftr_pkg::RegWrapPeriod: wrap_period_us <= cfg_data;
          cftr_pkg::RegSyncPeriod: sync_period_ns <= cfg_data;
          cftr_pkg::RegFramePeriod: frame_period_us <= cfg_data[23:0];
          cftr_pkg::RegFirstShift: first_frame_shift_us <= cfg_data[20:0];
          cftr_pkg::RegMatchMax: match_max_us <= cfg_data;
          cftr_pkg::RegMatchMin: match_min_us <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: if (in_ch.valid) begin
          ts <= in_ch.timestamp_word;
          sh <= in_ch.shutter_word;
          rx <= in_ch.received_ns;
          state <= S_DEC;
        end
        S_DEC: begin
          emb <= 27'(ts[31:25] * 27'd1000000) + 27'(ts[24:12] * 27'd125)
               + 27'(offs_prod[25:18]);
          state <= S_EXP;
        end
        S_EXP: begin
          exp_us <= (sh > 32'h70000000) ? mp : 64'd0;
          state <= S_INT;
        end
        S_INT: begin
          wrap_accum_us <= wacc_n;
          last_embedded_us <= emb;
          step <= intrinsic - last_intrinsic_us;
          last_intrinsic_us <= intrinsic;
          state <= S_DSYNC;
        end
        S_DSYNC: begin
          if (in_win) begin
            div_num <= {1'b0, rx};
            div_den <= 64'(sync_p);
            state <= S_WSYNC;
          end else begin
            neg <= step[63];
            div_num <= step[63] ? -step : step;
            div_den <= 64'(frame_p);
            state <= S_DSTEP;
          end
        end
        S_WSYNC: if (div_done) begin
          sync_multiple <= div_q;
          frames_since_sync <= 32'd1;
          synced <= 1'b1;
          state <= S_DLIM;
        end
        S_DSTEP: if (div_done) begin
          acc <= ({div_r, 1'b0} >= {1'b0, div_den}) ? div_q + 64'd1 : div_q;
          state <= S_ROUND;
        end
        S_ROUND: begin
          frames_since_sync <= frames_since_sync + (neg ? -acc[31:0] : acc[31:0]);
          state <= S_DLIM;
        end
        S_DLIM: begin
          div_num <= 64'(sync_p);
          div_den <= mp;
          state <= S_LIM;
        end
        S_LIM: if (div_done) begin
          limit <= div_q;
          state <= S_M0;
        end
        S_M0: begin acc <= mp; state <= S_M1; end
        S_M1: begin acc <= acc + {mp[31:0], 32'd0}; state <= S_M2; end
        S_M2: begin mreg <= mp; state <= S_M3; end
        // count sign-extended times frame period in ns, low 64 bits:
        // unsigned count times the low and high words, less the sign term
        S_M3: begin acc <= acc + mp; state <= S_M4; end
        S_M4: begin
          acc <= acc + {mp[31:0] - (count[31] ? mreg[31:0] : 32'd0), 32'd0};
          state <= S_FIN;
        end
        S_FIN: begin
          out_ch.frame_time_ns <= acc + exp_us * 64'd500
            + ((count == 32'sd1) ? 64'($signed(first_frame_shift_us) * 64'sd1000) : 64'd0);
          out_ch.time_valid <= synced && !(count > 0 && 64'(count) > limit);
          out_ch.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.frame_time_ns))
    else $error("result dropped");
  a_valid_sync: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.time_valid |-> synced) else $error("valid without sync");
`endif
endmodule

[tb/sv/cftr_checker.sv]
// checker for camera frame timestamp recovery: predicts each result from the
// accepted input transactions and register writes, compares field by field
// depends on cftr_pkg and the cftr_in_if / cftr_out_if interfaces
module cftr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cftr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cftr_pkg::CfgDataW-1:0] cfg_data,
  cftr_in_if                            in_ch,
  cftr_out_if                           out_ch,
  output int                            fail_count,
  output int                            pending,
  output int                            result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] frame_time_ns;
    logic        time_valid;
  } frame_result_t;

  // register copies
  logic [9:0]         shutter_step;
  logic [31:0]        wrap_period;
  logic [31:0]        sync_period;
  logic [23:0]        frame_period;
  logic signed [20:0] first_shift;
  logic [31:0]        win_max;
  logic [31:0]        win_min;

  // tracking state
  logic [31:0] prev_emb_us;
  logic [63:0] wrap_sum_us;
  logic [63:0] prev_intr_us;
  logic [63:0] sync_mult;
  logic [31:0] frame_count;
  logic        locked;

  frame_result_t expected_frames[$];

  function automatic frame_result_t recover_frame(input logic [31:0] ts,
                                                  input logic [31:0] sh,
                                                  input logic [62:0] rx);
    logic [63:0] sync_p, frame_p, exp_us, intr, delta, mag, q, r, lim, t;
    logic [31:0] emb;
    logic signed [63:0] s;
    logic signed [31:0] cnt;
    frame_result_t res;
    sync_p  = (sync_period == 0) ? 64'd1 : {32'd0, sync_period};
    frame_p = (frame_period == 0) ? 64'd1 : {40'd0, frame_period};
    emb = 32'(ts[31:25]) * 32'd1000000 + 32'(ts[24:12]) * 32'd125 + 32'(ts[11:0]) / 32'd25;
    exp_us = (sh > 32'h7000_0000) ? 64'(sh[19:0]) * 64'(shutter_step) : 64'd0;
    if (prev_emb_us > emb) wrap_sum_us = wrap_sum_us + 64'(wrap_period);
    prev_emb_us = emb;
    intr = wrap_sum_us + 64'(emb) - exp_us;
    delta = intr - prev_intr_us;
    prev_intr_us = intr;
    s = delta;
    if (s < $signed({32'd0, win_max}) && s > $signed({32'd0, win_min})) begin
      sync_mult = 64'(rx) / sync_p;
      frame_count = 32'd1;
      locked = 1'b1;
    end else begin
      // round half away from zero
      mag = delta[63] ? -delta : delta;
      q = mag / frame_p;
      r = mag % frame_p;
      if (2 * r >= frame_p) q = q + 1;
      if (delta[63]) q = -q;
      frame_count = frame_count + q[31:0];
    end
    cnt = frame_count;
    lim = sync_p / (frame_p * 64'd1000);
    res.time_valid = locked && !(cnt > 0 && 64'(cnt) > lim);
    t = sync_mult * sync_p + {{32{cnt[31]}}, cnt} * frame_p * 64'd1000;
    if (cnt == 1) t = t + {{43{first_shift[20]}}, first_shift} * 64'd1000;
    t = t + exp_us * 64'd500;
    res.frame_time_ns = t;
    return res;
  endfunction

  assign pending = expected_frames.size();

  always @(posedge clk) begin
    frame_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      shutter_step <= 10'd1;
      wrap_period <= 32'd128000000;
      sync_period <= 32'd1000000000;
      frame_period <= 24'd100000;
      first_shift <= '0;
      win_max <= 32'd150000;
      win_min <= 32'd50000;
      prev_emb_us = '0;
      wrap_sum_us = '0;
      prev_intr_us = '0;
      sync_mult = '0;
      frame_count = '0;
      locked = 1'b0;
      expected_frames.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cftr_pkg::RegShutterStep: shutter_step <= cfg_data[9:0];
          cftr_pkg::RegWrapPeriod:  wrap_period <= cfg_data;
          cftr_pkg::RegSyncPeriod:  sync_period <= cfg_data;
          cftr_pkg::RegFramePeriod: frame_period <= cfg_data[23:0];
          cftr_pkg::RegFirstShift:  first_shift <= cfg_data[20:0];
          cftr_pkg::RegMatchMax:    win_max <= cfg_data;
          cftr_pkg::RegMatchMin:    win_min <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_frames.push_back(recover_frame(in_ch.timestamp_word, in_ch.shutter_word,
                                                in_ch.received_ns));
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result transaction time=%h valid=%b", $time,
                   out_ch.frame_time_ns, out_ch.time_valid);
          errs++;
        end else begin
          want = expected_frames.pop_front();
          if (want.frame_time_ns !== out_ch.frame_time_ns) begin
            $display("%0t: frame_time_ns expected %h actual %h", $time,
                     want.frame_time_ns, out_ch.frame_time_ns);
            errs++;
          end
          if (want.time_valid !== out_ch.time_valid) begin
            $display("%0t: time_valid expected %b actual %b", $time,
                     want.time_valid, out_ch.time_valid);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
  end
endmodule

[tb/sv/tb_camera_frame_timestamp_recovery_core.sv]
// top of the camera frame timestamp recovery testbench: clock, reset,
// register phases, frame stimulus and verdict; depends on cftr_pkg,
// cftr_if, cftr_checker and the core
module tb_camera_frame_timestamp_recovery_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 30000;
  localparam int IdxW = cftr_pkg::CfgIdxW;
  localparam int DataW = cftr_pkg::CfgDataW;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [DataW-1:0] cfg_data = '0;
  int fail_count, pending, result_count;
  int sent = 0;
  int phases = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;

  // camera model for well-formed frame sequences
  logic [63:0] cam_us;
  logic [31:0] nominal_us;

  cftr_in_if in_ch (clk);
  cftr_out_if out_ch (clk);

  camera_frame_timestamp_recovery_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  cftr_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending),
    .result_count(result_count)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.timestamp_word = '0;
    in_ch.shutter_word = '0;
    in_ch.received_ns = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) out_ch.ready <= quiet || ($urandom_range(99) >= 15);

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_frame(input logic [31:0] ts, input logic [31:0] sh,
                            input logic [62:0] rx);
    if (!quiet && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.timestamp_word <= ts;
    in_ch.shutter_word <= sh;
    in_ch.received_ns <= rx;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  // idle the block, then write all seven registers
  task automatic load_regs(input logic [31:0] v[7]);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IdxW'(i);
      cfg_data <= v[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    phases++;
  endtask

  function automatic logic [31:0] encode_ts(input logic [63:0] us);
    logic [31:0] u, rem;
    u = 32'(us % 64'd128000000);
    rem = u % 1000000;
    return {7'(u / 1000000), 13'(rem / 125), 12'((rem % 125) * 25 + $urandom_range(24))};
  endfunction

  // camera frames, noise_pct percent of them noise, the rest well-formed or with broken steps
  task automatic run_frames(input int n, input int noise_pct);
    logic [63:0] dt;
    logic [31:0] sh;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 3 + n / 6);
      if ($urandom_range(99) < noise_pct) begin
        send_frame($urandom, $urandom, 63'({$urandom, $urandom}));
      end else begin
        dt = 64'(nominal_us) + 64'($urandom_range(nominal_us / 4)) - 64'(nominal_us / 8);
        case ($urandom_range(9))
          0: dt = dt * $urandom_range(2, 40);     // dropped frames
          1: dt = 64'($urandom_range(nominal_us / 3));
          default: ;
        endcase
        cam_us = cam_us + dt;
        sh = ($urandom_range(9) == 0) ? $urandom_range(32'h7000_0000)
                                     : {12'h800 | 12'($urandom_range(2047)),
                                        20'($urandom_range(3000))};
        send_frame(encode_ts(cam_us), sh, 63'(cam_us * 1000 + $urandom_range(5000000)));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [31:0] regs[7];
    logic [23:0] fp;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values written explicitly
    regs = '{32'd1, 32'd128000000, 32'd1000000000, 32'd100000, 32'd0, 32'd150000,
             32'd50000};
    load_regs(regs);
    send_frame(32'h0, 32'h0, 63'h0);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, {63{1'b1}});
    send_frame(32'h0, 32'h7000_0000, 63'd5);             // backward step, wrap
    send_frame(encode_ts(64'd100000), 32'h7000_0001, 63'd123456789);
    send_frame(encode_ts(64'd200000), 32'h7000_0000, 63'd2000000000);
    send_frame(encode_ts(64'd250000), 32'h0, 63'd2100000000);   // window edge
    send_frame(encode_ts(64'd300000), 32'h0, 63'd2200000000);
    send_frame(encode_ts(64'd450000), 32'h0, 63'd2300000000);   // upper edge
    send_frame(encode_ts(64'd500000), 32'h0, 63'd2400000000);   // half rounding
    send_frame(encode_ts(64'd100000), 32'h0, 63'd2500000000);   // negative step
    send_frame(encode_ts(64'd120000000), 32'h8000_0000, 63'd3);
    send_frame({7'd127, 13'h1FFF, 12'hFFF}, 32'hFFFF_FFFF, 63'd1);
    send_frame(32'h0000_0FFF, 32'h700F_FFFF, 63'd0);

    cam_us = 64'd127000000 - 64'($urandom_range(20000000));
    nominal_us = 32'd100000;
    regs[4] = 32'd250000;
    load_regs(regs);
    run_frames(700, 10);

    nominal_us = 32'd33333;
    regs = '{32'd10, 32'd128000000, 32'd1000000000, 32'd33333, 32'h001F_0BC0,
             32'd50000, 32'd20000};  // shift of -62528
    load_regs(regs);
    run_frames(400, 10);

    // extremes, zero periods act as one
    regs = '{32'd1023, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1000000, 32'hFFFF_FFFF, 32'd0};
    load_regs(regs);
    run_frames(150, 40);
    regs = '{32'd0, 32'd1, 32'd1, 32'hFF_FFFF, 32'h001F_FFFF, 32'd0, 32'hFFFF_FFFF};
    load_regs(regs);
    run_frames(150, 60);

    fp = 24'($urandom_range(1000, 200000));
    nominal_us = 32'(fp);
    regs = '{32'($urandom_range(1023)), $urandom, $urandom, 32'(fp),
             32'($urandom_range(2000000)) - 32'd1000000, 32'(fp) + 32'(fp / 2),
             32'(fp / 2)};
    load_regs(regs);
    run_frames(430, 15);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("sent %0d frame transactions over %0d register settings, checked %0d results",
             sent, phases, result_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

[filelist.f]
hdl/cftr_pkg.sv
hdl/cftr_if.sv
hdl/cftr_div.sv
hdl/camera_frame_timestamp_recovery_core.sv
tb/sv/cftr_checker.sv
tb/sv/tb_camera_frame_timestamp_recovery_core.sv
